[rtl/phfrs_pkg.sv]
// shared types, constants and a helper function for the packet header filter and sampler
package phfrs_pkg;

  // default parameter values
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int RATE_WIDTH_DEF  = 24;

  // fixed widths of the stream words and config port
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 72;
  localparam int CFG_DATA_W  = 32;
  localparam int TOTAL_W     = 32;
  localparam int LFSR_W      = 32;
  localparam int DIV_CNT_W   = $clog2(LFSR_W);

  // register reset values and lfsr taps
  localparam logic [31:0] RATE_RESET = 32'd256;
  localparam logic [LFSR_W-1:0] LFSR_RESET = 32'd1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 32'h8020_0003;

  // register indexes
  localparam logic REG_RATE        = 1'b0;
  localparam logic REG_RANDOM_SEED = 1'b1;

  // header constants
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETH_HDR_LEN  = 16'd14;
  localparam logic [15:0] VLAN_TAG_LEN = 16'd4;
  localparam logic [15:0] TCP_MIN_LEN  = 16'd13;
  localparam logic [15:0] UDP_HDR_LEN  = 16'd8;
  localparam logic [15:0] ICMP_HDR_LEN = 16'd8;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;

  // verdict codes
  typedef enum logic [2:0] {
    VERD_ELIGIBLE    = 3'd0,
    VERD_SHORT_ETH   = 3'd1,
    VERD_BAD_ETYPE   = 3'd2,
    VERD_SHORT_VLAN  = 3'd3,
    VERD_SHORT_IP    = 3'd4,
    VERD_BAD_PROTO   = 3'd5,
    VERD_SHORT_TRANS = 3'd6
  } verdict_e;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic start_draw;
    logic div_step;
    logic dec;
    logic out_load;
  } phfrs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic eligible;
    logic loaded;
    logic div_last;
    logic skip_one;
    logic hit;
  } phfrs_stat_t;

  // one step of the galois lfsr
  function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

[rtl/phfrs_ctrl.sv]
// controller state machine sequencing filter, skip draws and result hand-off
module phfrs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  phfrs_pkg::phfrs_stat_t stat_i,
  output phfrs_pkg::phfrs_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_DRAW = 5'b00100,
    S_DEC  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!stat_i.eligible) begin
          state_d = S_DONE;
        end else if (!stat_i.loaded) begin
          cmd_o.start_draw = 1'b1;
          state_d          = S_DRAW;
        end else begin
          state_d = S_DEC;
        end
      end
      S_DRAW: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = stat_i.hit ? S_DONE : S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.dec = 1'b1;
        if (stat_i.skip_one) begin
          cmd_o.start_draw = 1'b1;
          state_d          = S_DRAW;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output word valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/phfrs_dp.sv]
// datapath: header checks, lfsr, serial remainder, skip and packet counters
module phfrs_dp #(
  parameter int COUNT_WIDTH = phfrs_pkg::COUNT_WIDTH_DEF,
  parameter int RATE_WIDTH  = phfrs_pkg::RATE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [phfrs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [phfrs_pkg::IN_DATA_W-1:0]   in_data_i,
  output logic [phfrs_pkg::OUT_DATA_W-1:0]  out_data_o,
  input  phfrs_pkg::phfrs_cmd_t             cmd_i,
  output phfrs_pkg::phfrs_stat_t            stat_o
);

  localparam int MOD_W = RATE_WIDTH + 1;
  localparam int LW    = phfrs_pkg::LFSR_W;
  localparam int CW    = phfrs_pkg::DIV_CNT_W;

  // latched header fields
  logic [15:0] frame_length_q;
  logic [15:0] frame_type_q;
  logic [3:0]  ip_header_words_q;
  logic [7:0]  ip_protocol_q;
  logic [3:0]  tcp_header_words_q;

  // config and sampler state
  logic [RATE_WIDTH-1:0]  rate_q;
  logic [LW-1:0]          lfsr_q, lfsr_d;
  logic [MOD_W-1:0]       skip_q;
  logic                   loaded_q;
  logic                   hit_q;
  logic [COUNT_WIDTH-1:0] elig_cnt_q;
  logic [COUNT_WIDTH-1:0] samp_cnt_q;

  // remainder unit
  logic [MOD_W-1:0] mod_q;
  logic [MOD_W-1:0] rem_q;
  logic [MOD_W-1:0] rem_d;
  logic [LW-1:0]    dvd_q;
  logic [CW-1:0]    div_cnt_q;
  logic [MOD_W:0]   rem_shift;
  logic [RATE_WIDTH-1:0] rate_eff;
  logic [MOD_W-1:0] mod_d;

  logic [phfrs_pkg::OUT_DATA_W-1:0] out_data_q;
  phfrs_pkg::verdict_e verdict;

  // header checks
  always_comb begin
    logic [15:0] len1;
    logic [15:0] len2;
    logic [15:0] len3;
    logic [15:0] ihl_b;
    logic [15:0] tcp_b;
    ihl_b   = {10'd0, ip_header_words_q, 2'b00};
    tcp_b   = {10'd0, tcp_header_words_q, 2'b00};
    len1    = frame_length_q - phfrs_pkg::ETH_HDR_LEN;
    len2    = len1;
    len3    = '0;
    verdict = phfrs_pkg::VERD_ELIGIBLE;
    if (frame_length_q < phfrs_pkg::ETH_HDR_LEN) begin
      verdict = phfrs_pkg::VERD_SHORT_ETH;
    end else if (frame_type_q == phfrs_pkg::ETYPE_VLAN
                 && len1 < phfrs_pkg::VLAN_TAG_LEN) begin
      verdict = phfrs_pkg::VERD_SHORT_VLAN;
    end else if (frame_type_q != phfrs_pkg::ETYPE_IPV4 && frame_type_q != phfrs_pkg::ETYPE_ARP
                 && frame_type_q != phfrs_pkg::ETYPE_VLAN) begin
      verdict = phfrs_pkg::VERD_BAD_ETYPE;
    end else begin
      if (frame_type_q == phfrs_pkg::ETYPE_VLAN) begin
        len2 = len1 - phfrs_pkg::VLAN_TAG_LEN;
      end
      len3 = len2 - ihl_b;
      if (len2 == 16'd0 || len2 < ihl_b) begin
        verdict = phfrs_pkg::VERD_SHORT_IP;
      end else if (ip_protocol_q == phfrs_pkg::PROTO_TCP) begin
        if (len3 < phfrs_pkg::TCP_MIN_LEN || len3 < tcp_b) begin
          verdict = phfrs_pkg::VERD_SHORT_TRANS;
        end
      end else if (ip_protocol_q == phfrs_pkg::PROTO_UDP) begin
        if (len3 < phfrs_pkg::UDP_HDR_LEN) begin
          verdict = phfrs_pkg::VERD_SHORT_TRANS;
        end
      end else if (ip_protocol_q == phfrs_pkg::PROTO_ICMP) begin
        if (len3 < phfrs_pkg::ICMP_HDR_LEN) begin
          verdict = phfrs_pkg::VERD_SHORT_TRANS;
        end
      end else begin
        verdict = phfrs_pkg::VERD_BAD_PROTO;
      end
    end
  end

  // modulus 2n-1 with a zero rate taken as one
  assign rate_eff = (rate_q == '0) ? RATE_WIDTH'(1) : rate_q;
  assign mod_d    = {rate_eff, 1'b0} - MOD_W'(1);

  // one remainder bit per cycle, restoring
  assign rem_shift = {rem_q, dvd_q[LW-1]};
  assign rem_d = (rem_shift >= {1'b0, mod_q}) ? MOD_W'(rem_shift - {1'b0, mod_q})
                                               : rem_shift[MOD_W-1:0];

  assign lfsr_d = phfrs_pkg::lfsr_advance(lfsr_q);

  // input word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      frame_length_q     <= in_data_i[15:0];
      frame_type_q       <= in_data_i[31:16];
      ip_header_words_q  <= in_data_i[35:32];
      ip_protocol_q      <= in_data_i[43:36];
      tcp_header_words_q <= in_data_i[47:44];
    end
  end

  // remainder unit registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_draw) begin
      mod_q <= mod_d;
      rem_q <= '0;
      dvd_q <= lfsr_d;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[LW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.start_draw) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + CW'(1);
    end
  end

  // config registers and lfsr
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_WIDTH'(phfrs_pkg::RATE_RESET);
      lfsr_q <= phfrs_pkg::LFSR_RESET;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          phfrs_pkg::REG_RATE: begin
            rate_q <= cfg_data_i[RATE_WIDTH-1:0];
          end
          phfrs_pkg::REG_RANDOM_SEED: begin
            lfsr_q <= (cfg_data_i == '0) ? phfrs_pkg::LFSR_RESET : cfg_data_i;
          end
          default: begin
          end
        endcase
      end else if (cmd_i.start_draw) begin
        lfsr_q <= lfsr_d;
      end
    end
  end

  // skip counter and packet counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q     <= '0;
      loaded_q   <= 1'b0;
      hit_q      <= 1'b0;
      elig_cnt_q <= '0;
      samp_cnt_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        hit_q <= 1'b0;
      end
      if (cmd_i.dec) begin
        skip_q     <= skip_q - MOD_W'(1);
        elig_cnt_q <= elig_cnt_q + COUNT_WIDTH'(1);
        if (skip_q == MOD_W'(1)) begin
          hit_q      <= 1'b1;
          samp_cnt_q <= samp_cnt_q + COUNT_WIDTH'(1);
        end
      end
      if (cmd_i.div_step && div_cnt_q == CW'(LW - 1)) begin
        skip_q   <= rem_d + MOD_W'(1);
        loaded_q <= 1'b1;
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {4'b0000,
                     phfrs_pkg::TOTAL_W'(samp_cnt_q),
                     phfrs_pkg::TOTAL_W'(elig_cnt_q),
                     hit_q,
                     verdict};
    end
  end

  assign out_data_o = out_data_q;

  assign stat_o.eligible = (verdict == phfrs_pkg::VERD_ELIGIBLE);
  assign stat_o.loaded   = loaded_q;
  assign stat_o.div_last = (div_cnt_q == CW'(LW - 1));
  assign stat_o.skip_one = (skip_q == MOD_W'(1));
  assign stat_o.hit      = hit_q;

endmodule

[rtl/packet_header_filter_random_sampler_core.sv]
// top level of the packet header filter with random-skip packet sampler
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: header fields of one packet
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: verdict, sampled flag, totals
//  cfg       in   cfg_we_i                     cfg_idx_i, cfg_data_i
//
// a rejected packet goes from the check straight to its result word; an eligible one
// not sampled passes a decrement first; a sampled one, or the first eligible after reset,
// adds a draw, one that is both adds two (each draw is 32 remainder steps, a bit a cycle)
// one packet is in work at a time; a finished word waits in the output register while
// the next packet is taken, and the block stalls only when that word is still held
// reset clears the counters, the skip state and the lfsr to its default seed
module packet_header_filter_random_sampler_core #(
  parameter int COUNT_WIDTH = phfrs_pkg::COUNT_WIDTH_DEF,
  parameter int RATE_WIDTH  = phfrs_pkg::RATE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [phfrs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // header word in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // frame_length[15:0], frame_type[31:16], ip_header_words[35:32],
  // ip_protocol[43:36], tcp_header_words[47:44]
  input  logic [phfrs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // result word out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // verdict[2:0], sampled[3], eligible_total[35:4], sampled_total[67:36], zero[71:68]
  output logic [phfrs_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  phfrs_pkg::phfrs_cmd_t  cmd;
  phfrs_pkg::phfrs_stat_t stat;

  // sequencing
  phfrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // checks, draws and counters
  phfrs_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .RATE_WIDTH  (RATE_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

  // a sampled word always carries the eligible verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[3]) |-> (m_axis_tdata[2:0] == phfrs_pkg::VERD_ELIGIBLE))
    else $error("sampled word with a reject verdict");

  // one packet in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("new word taken while a packet is in work");

  // no two of draw start, remainder step, accept and output load are commanded together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start_draw, cmd.div_step, cmd.accept, cmd.out_load}))
    else $error("conflicting datapath commands");

  // a draw start follows either the first check or a decrement
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_draw |-> (stat.eligible && (cmd.dec || !stat.loaded)))
    else $error("draw started without an eligible packet");

endmodule
